FILE: src/gac_pkg.sv
`timescale 1ns / 1ps

package gac_pkg;

    // Operation codes carried in the request
    typedef enum logic [2:0] {
        OP_ALLOC       = 3'd0,
        OP_KERNEL_REQ  = 3'd1,
        OP_COPY_REQ    = 3'd2,
        OP_FREE        = 3'd3,
        OP_KERNEL_DONE = 3'd4,
        OP_COPY_DONE   = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_WAITING  = 2'd2,
        ST_REPORTED = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MEMORY_LIMIT     = 2'd0,
        CFG_CONTEXT_OVERHEAD = 2'd1,
        CFG_KERNEL_LIMIT     = 2'd2,
        CFG_COPY_LIMIT       = 2'd3
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_EXEC   = 2'd1,
        FSM_REPORT = 2'd2
    } fsm_t;

    localparam logic [7:0] COUNT_CEILING = 8'hFF;

    // Current state as seen by the update logic
    typedef struct packed {
        logic [63:0] total;
        logic [7:0]  kernel_count;
        logic [7:0]  copy_count;
        logic        kernel_empty;
        logic        kernel_full;
        logic        copy_empty;
        logic        copy_full;
        logic [7:0]  kernel_head_tag;
        logic [7:0]  copy_head_tag;
    } view_t;

    // Updates produced for one request
    typedef struct packed {
        status_t     status;
        logic        woken_valid;
        logic [7:0]  woken_tag;
        logic [63:0] total;
        logic [7:0]  kernel_count;
        logic [7:0]  copy_count;
        logic        kernel_push;
        logic        kernel_pop;
        logic        copy_push;
        logic        copy_pop;
    } update_t;

    // Slot available: below the ceiling, and below the limit (zero = unlimited)
    function automatic logic slot_free(input logic [7:0] count, input logic [7:0] limit);
        logic ok;
        begin
            ok = (count != COUNT_CEILING) && ((limit == 8'd0) || (count < limit));
            return ok;
        end
    endfunction

endpackage

FILE: src/gac_wait_mem.sv
`timescale 1ns / 1ps

module gac_wait_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    // Single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/gac_exec.sv
`timescale 1ns / 1ps

module gac_exec (
    input  gac_pkg::op_t     op,
    input  logic [63:0]      amount,
    input  logic [63:0]      memory_limit,
    input  logic [63:0]      context_overhead,
    input  logic [7:0]       kernel_limit,
    input  logic [7:0]       copy_limit,
    input  gac_pkg::view_t   view,
    output gac_pkg::update_t upd
);
    import gac_pkg::*;

    logic [64:0] alloc_sum;
    logic [64:0] free_diff;
    logic [63:0] avail;
    logic        alloc_ok;
    logic [7:0]  kernel_eff;
    logic [7:0]  kernel_dec;
    logic [7:0]  copy_dec;

    // Budget check: total + amount against limit less overhead; a zero limit checks only overflow
    assign alloc_sum = {1'b0, view.total} + {1'b0, amount};
    assign free_diff = {1'b0, view.total} - {1'b0, amount};
    assign avail     = memory_limit - context_overhead;

    always_comb
    begin
        if (memory_limit != 64'd0)
        begin
            alloc_ok = (context_overhead <= memory_limit) && (alloc_sum <= {1'b0, avail});
        end
        else
        begin
            alloc_ok = !alloc_sum[64];
        end
    end

    // Kernel limit of zero behaves as one
    assign kernel_eff = (kernel_limit == 8'd0) ? 8'd1 : kernel_limit;
    assign kernel_dec = (view.kernel_count != 8'd0) ? view.kernel_count - 8'd1 : 8'd0;
    assign copy_dec   = (view.copy_count != 8'd0) ? view.copy_count - 8'd1 : 8'd0;

    always_comb
    begin
        upd              = '0;
        upd.status       = ST_REFUSED;
        upd.total        = view.total;
        upd.kernel_count = view.kernel_count;
        upd.copy_count   = view.copy_count;
        unique case (op)
            OP_ALLOC:
            begin
                if (alloc_ok)
                begin
                    upd.total  = alloc_sum[63:0];
                    upd.status = ST_GRANTED;
                end
            end
            OP_KERNEL_REQ:
            begin
                if (view.kernel_empty && slot_free(view.kernel_count, kernel_eff))
                begin
                    upd.kernel_count = view.kernel_count + 8'd1;
                    upd.status       = ST_GRANTED;
                end
                else if (!view.kernel_full)
                begin
                    upd.kernel_push = 1'b1;
                    upd.status      = ST_WAITING;
                end
            end
            OP_COPY_REQ:
            begin
                if (view.copy_empty && slot_free(view.copy_count, copy_limit))
                begin
                    upd.copy_count = view.copy_count + 8'd1;
                    upd.status     = ST_GRANTED;
                end
                else if (!view.copy_full)
                begin
                    upd.copy_push = 1'b1;
                    upd.status    = ST_WAITING;
                end
            end
            OP_FREE:
            begin
                // floor at zero
                upd.total  = free_diff[64] ? 64'd0 : free_diff[63:0];
                upd.status = ST_REPORTED;
            end
            OP_KERNEL_DONE:
            begin
                upd.status       = ST_REPORTED;
                upd.kernel_count = kernel_dec;
                if (!view.kernel_empty && slot_free(kernel_dec, kernel_eff))
                begin
                    upd.kernel_pop   = 1'b1;
                    upd.woken_valid  = 1'b1;
                    upd.woken_tag    = view.kernel_head_tag;
                    upd.kernel_count = kernel_dec + 8'd1;
                end
            end
            OP_COPY_DONE:
            begin
                upd.status     = ST_REPORTED;
                upd.copy_count = copy_dec;
                if (!view.copy_empty && slot_free(copy_dec, copy_limit))
                begin
                    upd.copy_pop    = 1'b1;
                    upd.woken_valid = 1'b1;
                    upd.woken_tag   = view.copy_head_tag;
                    upd.copy_count  = copy_dec + 8'd1;
                end
            end
            default:
            begin
                upd.status = ST_REFUSED;
            end
        endcase
    end

endmodule

FILE: src/gpu_admission_controller_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// s_*       in   80     request: operation, amount, requester_tag
// m_*       out  96     result: status, woken, tag, bytes_in_use, counts
// cfg_*     in   64     register write: memory_limit, overhead, slot limits
//
// Each request passes through three steps: accept and wait-queue head read, update of
// the counters and queues, then the usage sum into the output register.
// The wait queues live in synchronous RAMs with a registered read port.
// A new request is taken only in idle, so a queue write always lands before
// the next head read. A stalled output holds the unit in its report step;
// a waiting result does not block the next request's accept.
// Reset (rst_n, async) empties the queues and zeroes the counts and totals.

module gpu_admission_controller_unit #(
    parameter int WAIT_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // operation[2:0], amount[66:3], requester_tag[74:67]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // status[1:0], woken_valid[2], woken_tag[10:3],
                                   // bytes_in_use[74:11], kernels_active[82:75],
                                   // copies_active[90:83]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import gac_pkg::*;

    localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int LW = $clog2(WAIT_DEPTH + 1);
    localparam int SW = LW + 1;
    localparam logic [LW-1:0] LEVEL_FULL = LW'(WAIT_DEPTH);
    localparam logic [SW-1:0] DEPTH_W    = SW'(WAIT_DEPTH);
    localparam logic [AW-1:0] HEAD_LAST  = AW'(WAIT_DEPTH - 1);

    fsm_t        state_reg, state_next;
    op_t         op_reg;
    logic [63:0] amount_reg;
    logic [7:0]  tag_reg;

    logic [63:0] memory_limit_reg;
    logic [63:0] context_overhead_reg;
    logic [7:0]  kernel_limit_reg;
    logic [7:0]  copy_limit_reg;

    logic [63:0]   total_reg;
    logic [7:0]    kernel_count_reg;
    logic [7:0]    copy_count_reg;
    logic [LW-1:0] kernel_level_reg;
    logic [LW-1:0] copy_level_reg;
    logic [AW-1:0] kernel_head_reg;
    logic [AW-1:0] copy_head_reg;

    status_t     status_reg;
    logic        woken_valid_reg;
    logic [7:0]  woken_tag_reg;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;

    logic        accept;
    logic [7:0]  kernel_rd;
    logic [7:0]  copy_rd;
    logic [AW-1:0] kernel_tail;
    logic [AW-1:0] copy_tail;
    logic [SW-1:0] kernel_tail_sum;
    logic [SW-1:0] copy_tail_sum;
    logic        exec_en;
    logic        out_load;
    logic [64:0] used_sum;
    logic [63:0] used;
    view_t       view;
    update_t     upd;

    assign s_tready = (state_reg == FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_en  = (state_reg == FSM_EXEC);
    assign out_load = (state_reg == FSM_REPORT) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                state_next = FSM_REPORT;
            end
            FSM_REPORT:
            begin
                if (out_load)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(s_tdata[2:0]);
            amount_reg <= s_tdata[66:3];
            tag_reg    <= s_tdata[74:67];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_limit_reg     <= 64'd0;
            context_overhead_reg <= 64'd0;
            kernel_limit_reg     <= 8'd1;
            copy_limit_reg       <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MEMORY_LIMIT:     memory_limit_reg     <= cfg_data;
                CFG_CONTEXT_OVERHEAD: context_overhead_reg <= cfg_data;
                CFG_KERNEL_LIMIT:     kernel_limit_reg     <= cfg_data[7:0];
                CFG_COPY_LIMIT:       copy_limit_reg       <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // Queue tails: head + level, wrapped once
    assign kernel_tail_sum = SW'(kernel_head_reg) + SW'(kernel_level_reg);
    assign copy_tail_sum   = SW'(copy_head_reg) + SW'(copy_level_reg);
    assign kernel_tail = (kernel_tail_sum >= DEPTH_W) ? AW'(kernel_tail_sum - DEPTH_W)
                                                      : AW'(kernel_tail_sum);
    assign copy_tail   = (copy_tail_sum >= DEPTH_W) ? AW'(copy_tail_sum - DEPTH_W)
                                                    : AW'(copy_tail_sum);

    gac_wait_mem #(.DEPTH(WAIT_DEPTH), .AW(AW)) u_kernel_q (
        .clk     (clk),
        .wr_en   (exec_en && upd.kernel_push),
        .wr_addr (kernel_tail),
        .wr_data (tag_reg),
        .rd_en   (accept),
        .rd_addr (kernel_head_reg),
        .rd_data (kernel_rd)
    );

    gac_wait_mem #(.DEPTH(WAIT_DEPTH), .AW(AW)) u_copy_q (
        .clk     (clk),
        .wr_en   (exec_en && upd.copy_push),
        .wr_addr (copy_tail),
        .wr_data (tag_reg),
        .rd_en   (accept),
        .rd_addr (copy_head_reg),
        .rd_data (copy_rd)
    );

    // Update logic
    always_comb
    begin
        view.total           = total_reg;
        view.kernel_count    = kernel_count_reg;
        view.copy_count      = copy_count_reg;
        view.kernel_empty    = (kernel_level_reg == '0);
        view.kernel_full     = (kernel_level_reg == LEVEL_FULL);
        view.copy_empty      = (copy_level_reg == '0);
        view.copy_full       = (copy_level_reg == LEVEL_FULL);
        view.kernel_head_tag = kernel_rd;
        view.copy_head_tag   = copy_rd;
    end

    gac_exec u_exec (
        .op               (op_reg),
        .amount           (amount_reg),
        .memory_limit     (memory_limit_reg),
        .context_overhead (context_overhead_reg),
        .kernel_limit     (kernel_limit_reg),
        .copy_limit       (copy_limit_reg),
        .view             (view),
        .upd              (upd)
    );

    // State write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg        <= 64'd0;
            kernel_count_reg <= 8'd0;
            copy_count_reg   <= 8'd0;
            kernel_level_reg <= '0;
            copy_level_reg   <= '0;
            kernel_head_reg  <= '0;
            copy_head_reg    <= '0;
        end
        else if (exec_en)
        begin
            total_reg        <= upd.total;
            kernel_count_reg <= upd.kernel_count;
            copy_count_reg   <= upd.copy_count;
            if (upd.kernel_push)
            begin
                kernel_level_reg <= kernel_level_reg + LW'(1);
            end
            else if (upd.kernel_pop)
            begin
                kernel_level_reg <= kernel_level_reg - LW'(1);
                kernel_head_reg  <= (kernel_head_reg == HEAD_LAST) ? '0
                                    : kernel_head_reg + AW'(1);
            end
            if (upd.copy_push)
            begin
                copy_level_reg <= copy_level_reg + LW'(1);
            end
            else if (upd.copy_pop)
            begin
                copy_level_reg <= copy_level_reg - LW'(1);
                copy_head_reg  <= (copy_head_reg == HEAD_LAST) ? '0 : copy_head_reg + AW'(1);
            end
        end
    end

    // Result fields held for the report step
    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            status_reg      <= upd.status;
            woken_valid_reg <= upd.woken_valid;
            woken_tag_reg   <= upd.woken_tag;
        end
    end

    // Usage snapshot, saturating
    assign used_sum = {1'b0, context_overhead_reg} + {1'b0, total_reg};
    assign used     = used_sum[64] ? {64{1'b1}} : used_sum[63:0];

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {5'd0, copy_count_reg, kernel_count_reg, used,
                            woken_tag_reg, woken_valid_reg, status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (kernel_level_reg <= LEVEL_FULL) && (copy_level_reg <= LEVEL_FULL))
        else $error("wait level beyond queue depth");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == FSM_EXEC))
        else $error("accepted request not executed next cycle");

    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en |-> !(upd.kernel_push && upd.kernel_pop) && !(upd.copy_push && upd.copy_pop))
        else $error("push and pop on one queue together");

    a_woken_report: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_REPORTED))
        else $error("wake-up reported without completion status");

endmodule
